### rtl/vtcv_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the vertex transform pipeline.
package vtcv_pkg;

    localparam int COORD_W      = 32;
    localparam int CFG_W        = 64;
    localparam int CFG_REGS     = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int CODE_W       = 6;
    localparam int QUOT_W       = 48;   // |num| * 2^16 and 2^32 both fit
    localparam int DIV_STEP     = 4;    // quotient bits per divider stage
    localparam int DIV_STAGES   = QUOT_W / DIV_STEP;
    localparam int SCALE_W      = 14;   // holds screen sizes up to 16383
    localparam int NQ_W         = QUOT_W + 1;
    localparam int SUM_W        = 66;
    localparam int S_TDATA_W    = 4 * COORD_W;
    localparam int M_TDATA_W    = 136;

    localparam int DEF_SCREEN_WIDTH  = 1024;
    localparam int DEF_SCREEN_HEIGHT = 768;

    // outcode bits
    localparam int CODE_Z_NEAR = 0;
    localparam int CODE_Z_FAR  = 1;
    localparam int CODE_X_LO   = 2;
    localparam int CODE_X_HI   = 3;
    localparam int CODE_Y_LO   = 4;
    localparam int CODE_Y_HI   = 5;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_REGS] = '{
        64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic [2:0]        num_neg;
        logic [2:0]        num_zero;
        logic              w_neg;
        logic              w_zero;
        logic [CODE_W-1:0] code;
    } t_side;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > 66'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

endpackage

### rtl/vtcv_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, unsigned, STEP quotient bits per stage.
module vtcv_divider #(
    parameter int DW   = vtcv_pkg::QUOT_W,
    parameter int VW   = vtcv_pkg::COORD_W,
    parameter int STEP = vtcv_pkg::DIV_STEP
) (
    input  logic                 i_clk,
    input  logic [DW/STEP-1:0]   i_en,
    input  logic [DW-1:0]        i_dividend,
    input  logic [VW-1:0]        i_divisor,
    output logic [DW-1:0]        o_quotient
);
    localparam int NSTG = DW / STEP;

    logic [VW-1:0] r_rem [NSTG];
    logic [DW-1:0] r_quo [NSTG];
    logic [VW-1:0] r_dvs [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [VW-1:0] n_rem;
        logic [DW-1:0] n_quo;
        logic [VW-1:0] rem_in;
        logic [DW-1:0] quo_in;
        logic [VW-1:0] dvs_in;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = i_dividend;
            assign dvs_in = i_divisor;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign dvs_in = r_dvs[s-1];
        end

        always_comb begin
            logic [VW:0]   t;
            logic [VW-1:0] rem;
            logic [DW-1:0] quo;
            rem = rem_in;
            quo = quo_in;
            // dividend bits shift out the top, quotient bits in at the bottom
            for (int k = 0; k < STEP; k++) begin
                t   = {rem, quo[DW-1]};
                quo = {quo[DW-2:0], 1'b0};
                if (t >= {1'b0, dvs_in}) begin
                    t      = t - {1'b0, dvs_in};
                    quo[0] = 1'b1;
                end
                rem = t[VW-1:0];
            end
            n_rem = rem;
            n_quo = quo;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_dvs[s] <= dvs_in;
            end
        end
    end

    assign o_quotient = r_quo[NSTG-1];

endmodule

### rtl/vertex_transform_clip_viewport_core.sv
`timescale 1ns / 1ps
// Vertex transform, clip outcode, perspective divide and viewport mapping.
// One vertex enters per clock and one result leaves per clock while the
// output is not stalled. The 12-stage divider (4 quotient bits per stage)
// lies between the matrix multiply/sum/clip stages and the sign, viewport
// scale and saturate stages. Each stage holds its data under a stall and
// takes new data as soon as the stage after it is free, so gaps in the
// stream close up. The user must write the matrix through the config port
// only while no transaction is in flight; the core does not enforce this.
module vertex_transform_clip_viewport_core #(
    parameter int SCREEN_WIDTH  = vtcv_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = vtcv_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vtcv_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [vtcv_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // in_x, in_y, in_z, in_w
    input  logic [vtcv_pkg::S_TDATA_W-1:0]    i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // screen_x, screen_y, depth, recip_w, clip_code, w_zero, zero pad
    output logic [vtcv_pkg::M_TDATA_W-1:0]    o_m_tdata
);
    localparam int CW     = vtcv_pkg::COORD_W;
    localparam int NDIV   = vtcv_pkg::DIV_STAGES;
    localparam int S_DIV0 = 3;
    localparam int S_P1   = S_DIV0 + NDIV;
    localparam int S_P2   = S_P1 + 1;
    localparam int S_OUT  = S_P1 + 2;
    localparam int NS     = S_OUT + 1;
    localparam int QW     = vtcv_pkg::QUOT_W;
    localparam int NQW    = vtcv_pkg::NQ_W;
    localparam int SW     = vtcv_pkg::SCALE_W;
    localparam int SUMW   = vtcv_pkg::SUM_W;

    localparam logic [SW-1:0] SCR_W = SW'(SCREEN_WIDTH);
    localparam logic [SW-1:0] SCR_H = SW'(SCREEN_HEIGHT);

    // ---- configuration ----
    logic [vtcv_pkg::CFG_W-1:0] r_cfg [vtcv_pkg::CFG_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= vtcv_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // ---- stage handshake ----
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_v[NS-1];

    // ---- stage 0: products ----
    logic signed [2*CW-1:0] r_prod [4][4];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_prod[r][c] <= $signed(i_s_tdata[r*CW +: CW])
                        * $signed(r_cfg[r*2 + c/2][(1 - c%2)*CW +: CW]);
                end
            end
        end
    end

    // ---- stage 1: column sums, floor to Q16.16, saturate ----
    logic [CW-1:0] r_clip [4];

    always_ff @(posedge i_clk) begin
        logic signed [SUMW-1:0] sum;
        if (en[1]) begin
            for (int c = 0; c < 4; c++) begin
                sum = '0;
                for (int r = 0; r < 4; r++) begin
                    sum = sum + SUMW'(r_prod[r][c]);
                end
                r_clip[c] <= vtcv_pkg::sat32(sum >>> 16);
            end
        end
    end

    // ---- stage 2: outcode, magnitudes for the divider ----
    vtcv_pkg::t_side r_side2;
    logic [QW-1:0]   r_dvd [4];
    logic [CW-1:0]   r_dvs;

    always_ff @(posedge i_clk) begin
        logic signed [CW:0] x, y, z, w, nw;
        logic [CW-1:0]      mag;
        if (en[2]) begin
            x  = {r_clip[0][CW-1], r_clip[0]};
            y  = {r_clip[1][CW-1], r_clip[1]};
            z  = {r_clip[2][CW-1], r_clip[2]};
            w  = {r_clip[3][CW-1], r_clip[3]};
            nw = -w;
            r_side2.code[vtcv_pkg::CODE_Z_NEAR] <= z < 0;
            r_side2.code[vtcv_pkg::CODE_Z_FAR]  <= z > w;
            r_side2.code[vtcv_pkg::CODE_X_LO]   <= x < nw;
            r_side2.code[vtcv_pkg::CODE_X_HI]   <= x > w;
            r_side2.code[vtcv_pkg::CODE_Y_LO]   <= y < nw;
            r_side2.code[vtcv_pkg::CODE_Y_HI]   <= y > w;
            r_side2.w_neg  <= r_clip[3][CW-1];
            r_side2.w_zero <= r_clip[3] == '0;
            for (int i = 0; i < 3; i++) begin
                r_side2.num_neg[i]  <= r_clip[i][CW-1];
                r_side2.num_zero[i] <= r_clip[i] == '0;
                mag = r_clip[i][CW-1] ? -r_clip[i] : r_clip[i];
                r_dvd[i] <= {mag, 16'h0000};
            end
            r_dvd[3] <= QW'(64'h1_0000_0000);
            r_dvs    <= r_clip[3][CW-1] ? -r_clip[3] : r_clip[3];
        end
    end

    // ---- divider stages ----
    logic [QW-1:0]   quo [4];
    vtcv_pkg::t_side r_side_d [NDIV];

    for (genvar i = 0; i < 4; i++) begin : g_div
        vtcv_divider #(
            .DW   (QW),
            .VW   (CW),
            .STEP (vtcv_pkg::DIV_STEP)
        ) u_div (
            .i_clk      (i_clk),
            .i_en       (en[S_DIV0 +: NDIV]),
            .i_dividend (r_dvd[i]),
            .i_divisor  (r_dvs),
            .o_quotient (quo[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[S_DIV0]) begin
            r_side_d[0] <= r_side2;
        end
        for (int s = 1; s < NDIV; s++) begin
            if (en[S_DIV0 + s]) begin
                r_side_d[s] <= r_side_d[s-1];
            end
        end
    end

    // ---- post 1: signs, zero-w override, viewport offsets ----
    vtcv_pkg::t_side        side_q;
    logic signed [NQW-1:0]  r_a, r_b;
    logic [CW-1:0]          r_depth, r_rw;
    logic [vtcv_pkg::CODE_W-1:0] r_code1;
    logic                   r_wz1;

    assign side_q = r_side_d[NDIV-1];

    always_ff @(posedge i_clk) begin
        logic signed [NQW-1:0] nq [3];
        logic signed [NQW-1:0] rq;
        if (en[S_P1]) begin
            for (int i = 0; i < 3; i++) begin
                if (side_q.w_zero) begin
                    // full scale with the numerator's sign
                    if (side_q.num_zero[i]) begin
                        nq[i] = '0;
                    end else if (side_q.num_neg[i]) begin
                        nq[i] = -(NQW'(1) <<< (QW - 1));
                    end else begin
                        nq[i] = NQW'(1) <<< (QW - 1);
                    end
                end else if (side_q.num_neg[i] ^ side_q.w_neg) begin
                    nq[i] = -$signed({1'b0, quo[i]});
                end else begin
                    nq[i] = $signed({1'b0, quo[i]});
                end
            end
            rq = side_q.w_neg ? -$signed({1'b0, quo[3]}) : $signed({1'b0, quo[3]});
            r_a     <= nq[0] + NQW'(65536);
            r_b     <= NQW'(65536) - nq[1];
            r_depth <= vtcv_pkg::sat32(SUMW'(nq[2]));
            r_rw    <= side_q.w_zero ? 32'h7FFF_FFFF : vtcv_pkg::sat32(SUMW'(rq));
            r_code1 <= side_q.code;
            r_wz1   <= side_q.w_zero;
        end
    end

    // ---- post 2: scale by screen size ----
    logic signed [2*CW-1:0] r_pa, r_pb;
    logic [CW-1:0]          r_depth2, r_rw2;
    logic [vtcv_pkg::CODE_W-1:0] r_code2;
    logic                   r_wz2;

    always_ff @(posedge i_clk) begin
        if (en[S_P2]) begin
            r_pa     <= (2*CW)'(r_a) * (2*CW)'($signed({1'b0, SCR_W}));
            r_pb     <= (2*CW)'(r_b) * (2*CW)'($signed({1'b0, SCR_H}));
            r_depth2 <= r_depth;
            r_rw2    <= r_rw;
            r_code2  <= r_code1;
            r_wz2    <= r_wz1;
        end
    end

    // ---- output register: halve (floor) and saturate ----
    logic [CW-1:0]               r_sx, r_sy, r_depth3, r_rw3;
    logic [vtcv_pkg::CODE_W-1:0] r_code3;
    logic                        r_wz3;

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            r_sx     <= vtcv_pkg::sat32(SUMW'(r_pa >>> 1));
            r_sy     <= vtcv_pkg::sat32(SUMW'(r_pb >>> 1));
            r_depth3 <= r_depth2;
            r_rw3    <= r_rw2;
            r_code3  <= r_code2;
            r_wz3    <= r_wz2;
        end
    end

    assign o_m_tdata = {1'b0, r_wz3, r_code3, r_rw3, r_depth3, r_sy, r_sx};

endmodule

### rtl/vtcv_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the vertex transform core, bound to the top level.
module vtcv_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [vtcv_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    logic [31:0] recip_w;
    logic [5:0]  code;
    logic        w_zero;

    assign recip_w = o_m_tdata[127:96];
    assign code    = o_m_tdata[133:128];
    assign w_zero  = o_m_tdata[134];

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled transaction changed");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input stalled while output drains");

    a_wzero_recip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_zero |-> recip_w == 32'h7FFF_FFFF)
        else $error("zero w without saturated reciprocal");

    a_wzero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_zero |-> !(code[0] && code[1]) && !(code[2] && code[3])
                                 && !(code[4] && code[5]))
        else $error("contradictory outcode at zero w");

endmodule

bind vertex_transform_clip_viewport_core vtcv_checker u_vtcv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
